// ----- hdl/sfr_pkg.sv -----
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

    localparam logic [7:0] ADDR_FLAG  = 8'h80;
    localparam logic [7:0] ESC_LIMIT  = 8'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] REG_EXPECTED_TAG = 2'd0;
    localparam logic [1:0] REG_NODE_ADDRESS = 2'd1;

    typedef enum logic [2:0] {
        PH_TAG  = 3'd0,
        PH_ADDR = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TAG      = 3'd1,
        ST_ADDRESS  = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_ESCAPE   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] expected_tag;
        logic [6:0] node_address;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] index;
        t_status    status;
        logic [7:0] length;
        logic       last;
    } t_result;

endpackage

// ----- hdl/stuffed_frame_receiver.sv -----
// Byte-stuffed serial frame receiver top level.
// Takes one line byte per clock cycle while o_stall is low: the parser
// updates its frame state on every accepted beat, and a result beat goes
// into a QUEUE_DEPTH-entry result queue between parser and output register,
// from which the output register pops it. The input stalls only while that
// queue is full under output back-pressure. The user must write configuration
// (tag, node address) only while idle; the block does not enforce it.
module stuffed_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_result_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_frame_length,
    output logic       o_last
);

    sfr_pkg::t_cfg    r_cfg;
    sfr_pkg::t_result w_push_data;
    sfr_pkg::t_result w_head;
    sfr_pkg::t_result w_beat;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfr_pkg::REG_EXPECTED_TAG: r_cfg.expected_tag <= i_cfg_data;
                sfr_pkg::REG_NODE_ADDRESS: r_cfg.node_address <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    sfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_push    (w_push),
        .o_result  (w_push_data)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    sfr_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (w_beat)
    );

    assign o_result_kind  = w_beat.kind;
    assign o_data_byte    = w_beat.data;
    assign o_byte_index   = w_beat.index;
    assign o_frame_status = w_beat.status;
    assign o_frame_length = w_beat.length;
    assign o_last         = w_beat.last;

endmodule

// ----- hdl/sfr_parser.sv -----
// Front end: frame parser, one line byte per accepted beat.
module sfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  sfr_pkg::t_cfg    i_cfg,
    output logic             o_push,
    output sfr_pkg::t_result o_result
);

    sfr_pkg::t_phase r_phase, n_phase;
    logic            r_esc, n_esc;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_seen, n_seen;

    logic            w_esc_phase;
    logic            w_low;
    logic            w_prefix;
    logic            w_bad;
    logic [7:0]      w_val;
    logic [7:0]      w_sum_add;
    logic [7:0]      w_seen_inc;
    logic            w_addr_ok;
    logic            w_res_valid;

    assign w_esc_phase = (r_phase == sfr_pkg::PH_LEN) || (r_phase == sfr_pkg::PH_DATA) ||
                         (r_phase == sfr_pkg::PH_CSUM);
    assign w_low      = i_rx_byte < sfr_pkg::ESC_LIMIT;
    assign w_prefix   = w_esc_phase && !r_esc && w_low;
    assign w_bad      = w_esc_phase && r_esc && w_low;
    assign w_val      = r_esc ? i_rx_byte - sfr_pkg::ESC_LIMIT : i_rx_byte;
    assign w_sum_add  = r_sum + w_val;
    assign w_seen_inc = r_seen + 8'd1;
    assign w_addr_ok  = ((i_rx_byte & sfr_pkg::ADDR_FLAG) != 8'd0) &&
                        (i_rx_byte[6:0] == i_cfg.node_address);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_sum   = r_sum;
        n_len   = r_len;
        n_seen  = r_seen;
        case (r_phase)
            sfr_pkg::PH_ADDR: begin
                if (!w_addr_ok) begin
                    n_phase = sfr_pkg::PH_TAG;
                    n_esc   = 1'b0;
                end else begin
                    n_sum   = i_rx_byte;
                    n_phase = sfr_pkg::PH_LEN;
                end
            end
            sfr_pkg::PH_LEN, sfr_pkg::PH_DATA, sfr_pkg::PH_CSUM: begin
                if (w_bad) begin
                    n_phase = sfr_pkg::PH_TAG;
                    n_esc   = 1'b0;
                end else if (w_prefix) begin
                    n_esc = 1'b1;
                end else begin
                    n_esc = 1'b0;
                    n_sum = w_sum_add;
                    if (r_phase == sfr_pkg::PH_LEN) begin
                        n_len   = w_val;
                        n_seen  = 8'd0;
                        n_phase = (w_val == 8'd0) ? sfr_pkg::PH_CSUM : sfr_pkg::PH_DATA;
                    end else if (r_phase == sfr_pkg::PH_DATA) begin
                        n_seen = w_seen_inc;
                        if (w_seen_inc >= r_len) begin
                            n_phase = sfr_pkg::PH_CSUM;
                        end
                    end else begin
                        n_phase = sfr_pkg::PH_TAG;
                    end
                end
            end
            default: begin
                if (i_rx_byte != i_cfg.expected_tag) begin
                    n_phase = sfr_pkg::PH_TAG;
                    n_esc   = 1'b0;
                end else begin
                    n_sum   = 8'd0;
                    n_len   = 8'd0;
                    n_seen  = 8'd0;
                    n_esc   = 1'b0;
                    n_phase = sfr_pkg::PH_ADDR;
                end
            end
        endcase
    end

    // result beat
    always_comb begin
        w_res_valid     = 1'b0;
        o_result.kind   = sfr_pkg::KIND_STATUS;
        o_result.data   = 8'd0;
        o_result.index  = 8'd0;
        o_result.status = sfr_pkg::ST_OK;
        o_result.length = 8'd0;
        o_result.last   = 1'b1;
        case (r_phase)
            sfr_pkg::PH_ADDR: begin
                if (!w_addr_ok) begin
                    w_res_valid     = 1'b1;
                    o_result.status = sfr_pkg::ST_ADDRESS;
                end
            end
            sfr_pkg::PH_LEN, sfr_pkg::PH_DATA, sfr_pkg::PH_CSUM: begin
                if (w_bad) begin
                    w_res_valid     = 1'b1;
                    o_result.status = sfr_pkg::ST_ESCAPE;
                    o_result.length = (r_phase == sfr_pkg::PH_LEN) ? 8'd0 : r_len;
                end else if (!w_prefix) begin
                    if (r_phase == sfr_pkg::PH_DATA) begin
                        w_res_valid     = 1'b1;
                        o_result.kind   = sfr_pkg::KIND_DATA;
                        o_result.data   = w_val;
                        o_result.index  = r_seen;
                        o_result.length = r_len;
                        o_result.last   = 1'b0;
                    end else if (r_phase == sfr_pkg::PH_CSUM) begin
                        w_res_valid     = 1'b1;
                        o_result.status = (w_sum_add == 8'd0) ? sfr_pkg::ST_OK
                                                              : sfr_pkg::ST_CHECKSUM;
                        o_result.length = r_len;
                    end
                end
            end
            default: begin
                if (i_rx_byte != i_cfg.expected_tag) begin
                    w_res_valid     = 1'b1;
                    o_result.status = sfr_pkg::ST_TAG;
                end
            end
        endcase
    end

    assign o_push = i_accept && w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfr_pkg::PH_TAG;
            r_esc   <= 1'b0;
            r_sum   <= 8'd0;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_seen  <= n_seen;
        end
    end

endmodule

// ----- hdl/sfr_queue.sv -----
// Short result queue between parser and output stage.
module sfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfr_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output sfr_pkg::t_result o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::t_result   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
        end
        if (i_pop) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/sfr_emitter.sv -----
// Back end: output register that drains the result queue.
module sfr_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  sfr_pkg::t_result i_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output sfr_pkg::t_result o_beat
);

    logic             r_valid;
    sfr_pkg::t_result r_beat;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= i_data;
        end
    end

endmodule

// ----- hdl/sfr_checker.sv -----
// Port-level checks for the stuffed frame receiver, bound to the top level.
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_result_kind,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_byte_index,
    input logic [2:0] o_frame_status,
    input logic [7:0] o_frame_length,
    input logic       o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) &&
            $stable(o_data_byte) && $stable(o_byte_index) &&
            $stable(o_frame_status) && $stable(o_frame_length) && $stable(o_last))
        else $error("stalled output beat changed");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

    a_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_result_kind) &&
            (o_result_kind || (o_frame_status == sfr_pkg::ST_OK &&
                               o_byte_index < o_frame_length)))
        else $error("malformed result beat");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_kind  (o_result_kind),
    .o_data_byte    (o_data_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_status (o_frame_status),
    .o_frame_length (o_frame_length),
    .o_last         (o_last)
);
